// File: src/msb_first_bitstream_access_core_macros.svh
// Assertion macros for the checker file of the bitstream access core.
`ifndef MSB_FIRST_BITSTREAM_ACCESS_CORE_MACROS_SVH
`define MSB_FIRST_BITSTREAM_ACCESS_CORE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MFBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MFBA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/mfba_pkg.sv
// Package of the bitstream access core: sizes, codes and controller/datapath link types.
package mfba_pkg;

   localparam int BUFFER_BYTES = 4096;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
   localparam int LEN_W        = 13;
   localparam int CMP_W        = (POS_W > LEN_W) ? POS_W : LEN_W;

   localparam int OPCODE_W     = 3;
   localparam int COUNT_W      = 6;
   localparam int WORD_W       = 32;
   localparam int BADDR_W      = 12;
   localparam int BYTE_W       = 8;
   localparam int LEFT_W       = 4;

   localparam logic [POS_W-1:0]   BUF_END   = POS_W'(BUFFER_BYTES);
   localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(4096);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(WORD_W);
   localparam logic [LEFT_W-1:0]  BYTE_BITS = LEFT_W'(BYTE_W);

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD    = 3'd0,
      OP_FETCH   = 3'd1,
      OP_READ    = 3'd2,
      OP_WRITE   = 3'd3,
      OP_RESTART = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_WAIT,
      ST_STEP,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;      // latch the request fields
      logic mem_load;     // store request byte
      logic fetch_issue;  // read store at request address
      logic fetch_capture;
      logic byte_issue;   // read store at byte position
      logic chunk;        // consume bits from the current byte
      logic from_mem;     // current byte comes from the store read data
      logic is_write;
      logic restart;
      logic respond;      // load the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic left_zero;
      logic at_end;
      logic out_free;
   } dp_status_type;

endpackage

// File: src/mfba_channels.sv
// Valid/ready channel interfaces for request and response transactions.
interface mfba_req_if import mfba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COUNT_W-1:0]  bit_count;
   logic [WORD_W-1:0]   write_value;
   logic [BADDR_W-1:0]  byte_address;
   logic [BYTE_W-1:0]   byte_data;

   modport source (output valid, opcode, bit_count, write_value, byte_address, byte_data,
                   input ready);
   modport sink (input valid, opcode, bit_count, write_value, byte_address, byte_data,
                 output ready);
endinterface

interface mfba_rsp_if import mfba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_value;
   logic [BYTE_W-1:0] fetched_byte;
   logic              overrun;

   modport source (output valid, read_value, fetched_byte, overrun, input ready);
   modport sink (input valid, read_value, fetched_byte, overrun, output ready);
endinterface

// File: src/mfba_ctrl.sv
// Controller state machine of the bitstream access core.
module mfba_ctrl import mfba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   input  dp_status_type       status,
   output ctrl_cmd_type        cmd
);

   state_type  state_ff, state_in;
   logic       write_ff, write_in;
   opcode_type op;
   logic       accept;

   assign op        = opcode_type'(req_opcode);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign write_in  = accept ? (op == OP_WRITE) : write_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         write_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         write_ff <= write_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op)
                  OP_FETCH: state_in = ST_FETCH_WAIT;
                  OP_READ:  state_in = ST_STEP;
                  OP_WRITE: state_in = ST_STEP;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_FETCH_WAIT: state_in = ST_RESP;
         ST_STEP: begin
            if (status.count_zero) begin
               state_in = ST_RESP;
            end else if (status.left_zero && !status.at_end) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: state_in = ST_STEP;
         ST_RESP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.is_write = write_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (op)
                  OP_LOAD:    cmd.mem_load    = 1'b1;
                  OP_FETCH:   cmd.fetch_issue = 1'b1;
                  OP_RESTART: cmd.restart     = 1'b1;
                  default:    cmd.capture     = 1'b1;
               endcase
            end
         end
         ST_FETCH_WAIT: cmd.fetch_capture = 1'b1;
         ST_STEP: begin
            if (!status.count_zero) begin
               if (status.left_zero && !status.at_end) begin
                  cmd.byte_issue = 1'b1;
               end else begin
                  cmd.chunk = 1'b1;
               end
            end
         end
         ST_FILL: begin
            cmd.chunk    = 1'b1;
            cmd.from_mem = 1'b1;
         end
         ST_RESP: cmd.respond = status.out_free;
         default: cmd.respond = 1'b0;
      endcase
   end

endmodule

// File: src/mfba_datapath.sv
// Datapath of the bitstream access core: byte store, bit cursor and result register.
module mfba_datapath import mfba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [LEN_W-1:0]    csr_write_data,
   input  logic [COUNT_W-1:0]  req_bit_count,
   input  logic [WORD_W-1:0]   req_write_value,
   input  logic [BADDR_W-1:0]  req_byte_address,
   input  logic [BYTE_W-1:0]   req_byte_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_read_value,
   output logic [BYTE_W-1:0]   rsp_fetched_byte,
   output logic                rsp_overrun,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status
);

   logic [BYTE_W-1:0] mem [BUFFER_BYTES];

   logic [LEN_W-1:0]   len_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [BYTE_W-1:0]  cur_ff;
   logic [LEFT_W-1:0]  left_ff;
   logic               ovr_ff;
   logic               past_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [WORD_W-1:0]  wval_ff;
   logic [WORD_W-1:0]  rval_ff;
   logic [BYTE_W-1:0]  fetched_ff;
   logic               addr_ok_ff;
   logic [BYTE_W-1:0]  mem_q_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_rval_ff;
   logic [BYTE_W-1:0]  rsp_fetched_ff;
   logic               rsp_ovr_ff;

   logic [BYTE_W-1:0]  src_cur;
   logic [LEFT_W-1:0]  src_left;
   logic [POS_W-1:0]   src_pos;
   logic               src_past;
   logic               src_ovr;
   logic [POS_W-1:0]   pos_inc;
   logic [LEFT_W-1:0]  reach;
   logic [LEFT_W-1:0]  rest;
   logic [LEFT_W-1:0]  new_left;
   logic [BYTE_W-1:0]  cur_shl;
   logic [BYTE_W-1:0]  top_bits;
   logic [BYTE_W-1:0]  new_cur;
   logic [WORD_W-1:0]  rd_next;
   logic               store_back;
   logic               addr_ok;
   logic [COUNT_W-1:0] count_sat;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [BYTE_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;

   assign addr_ok   = (32'(req_byte_address) < BUFFER_BYTES);
   assign count_sat = (req_bit_count > COUNT_MAX) ? COUNT_MAX : req_bit_count;
   assign pos_inc   = pos_ff + POS_W'(1);

   // byte under the cursor: fresh from the store, blank past the end, or the held one
   always_comb begin
      if (cmd.from_mem) begin
         src_cur  = mem_q_ff;
         src_left = BYTE_BITS;
         src_pos  = pos_inc;
         src_past = 1'b0;
         src_ovr  = ovr_ff || (CMP_W'(pos_inc) > CMP_W'(len_ff));
      end else if (left_ff == '0) begin
         src_cur  = '0;
         src_left = BYTE_BITS;
         src_pos  = pos_ff;
         src_past = 1'b1;
         src_ovr  = 1'b1;
      end else begin
         src_cur  = cur_ff;
         src_left = left_ff;
         src_pos  = pos_ff;
         src_past = past_ff;
         src_ovr  = ovr_ff;
      end
   end

   assign reach    = (COUNT_W'(src_left) < count_ff) ? src_left : LEFT_W'(count_ff);
   assign rest     = BYTE_BITS - reach;
   assign new_left = src_left - reach;
   assign cur_shl  = src_cur << reach;
   assign top_bits = wval_ff[WORD_W-1 -: BYTE_W] >> rest;
   assign new_cur  = cmd.is_write ? (cur_shl | top_bits) : cur_shl;
   assign rd_next  = (rval_ff << reach) | WORD_W'(src_cur >> rest);

   // a completed byte goes back to the slot it came from
   assign store_back = cmd.chunk && cmd.is_write && (new_left == '0) && (src_pos != '0) &&
                       !src_past && (src_pos <= BUF_END);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ADDR_W'(req_byte_address);
      mem_wdata = req_byte_data;
      if (cmd.mem_load) begin
         mem_we = addr_ok;
      end else if (store_back) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(src_pos - POS_W'(1));
         mem_wdata = new_cur;
      end
   end

   assign mem_re    = cmd.fetch_issue || cmd.byte_issue;
   assign mem_raddr = cmd.byte_issue ? ADDR_W'(pos_ff) : ADDR_W'(req_byte_address);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   // cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_RESET;
         pos_ff  <= '0;
         cur_ff  <= '0;
         left_ff <= '0;
         ovr_ff  <= 1'b0;
         past_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
         if (cmd.restart) begin
            pos_ff  <= '0;
            cur_ff  <= '0;
            left_ff <= '0;
            ovr_ff  <= 1'b0;
            past_ff <= 1'b0;
         end else if (cmd.chunk) begin
            pos_ff  <= src_pos;
            cur_ff  <= new_cur;
            left_ff <= new_left;
            ovr_ff  <= src_ovr;
            past_ff <= src_past;
         end
      end
   end

   // per-transaction working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         count_ff   <= count_sat;
         wval_ff    <= req_write_value;
         rval_ff    <= '0;
         fetched_ff <= '0;
         addr_ok_ff <= addr_ok;
      end else begin
         if (cmd.chunk) begin
            count_ff <= count_ff - COUNT_W'(reach);
            wval_ff  <= wval_ff << reach;
            if (!cmd.is_write) begin
               rval_ff <= rd_next;
            end
         end
         if (cmd.fetch_capture) begin
            fetched_ff <= addr_ok_ff ? mem_q_ff : '0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_rval_ff    <= rval_ff;
         rsp_fetched_ff <= fetched_ff;
         rsp_ovr_ff     <= ovr_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_rval_ff;
   assign rsp_fetched_byte = rsp_fetched_ff;
   assign rsp_overrun      = rsp_ovr_ff;

   assign status.count_zero = (count_ff == '0);
   assign status.left_zero  = (left_ff == '0);
   assign status.at_end     = (pos_ff == BUF_END);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: src/msb_first_bitstream_access_core.sv
// Top level of the MSB-first bitstream access core.
// Accept to result load: load byte, restart, unknown opcode go to the response; fetch byte
// reads the store, then captures it; read/write bits: a read and fill step per store byte,
// a chunk step per held or past-end byte. A waiting result stalls the response. One
// transaction at a time, one registered store access per cycle; a new request is taken
// while a result waits. Sync reset clears cursor, overrun, handshake state; length to 4096.
module msb_first_bitstream_access_core import mfba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   mfba_req_if.sink         req_chan,
   mfba_rsp_if.source       rsp_chan,
   input  logic             csr_write_enable,
   input  logic [LEN_W-1:0] csr_write_data
);

   ctrl_cmd_type  cmd;     // controller -> datapath
   dp_status_type status;  // datapath -> controller

   // Controller: walks each transaction through fetch, byte-fill and chunk steps.
   mfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: byte store, position/bit cursor, shifter and result register.
   mfba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bit_count    (req_chan.bit_count),
      .req_write_value  (req_chan.write_value),
      .req_byte_address (req_chan.byte_address),
      .req_byte_data    (req_chan.byte_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_read_value   (rsp_chan.read_value),
      .rsp_fetched_byte (rsp_chan.fetched_byte),
      .rsp_overrun      (rsp_chan.overrun),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: src/mfba_checker.sv
// Port-level checker of the bitstream access core, bound to the top level.
`include "msb_first_bitstream_access_core_macros.svh"

module mfba_checker import mfba_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_read_value,
   input logic [BYTE_W-1:0] rsp_fetched_byte,
   input logic              rsp_overrun
);

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   rsp_wait;
   logic [WORD_W+BYTE_W:0] rsp_data;
   logic [1:0]             inflight_ff, inflight_in;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign rsp_wait    = rsp_valid && !rsp_ready;
   assign rsp_data    = {rsp_read_value, rsp_fetched_byte, rsp_overrun};
   assign inflight_in = inflight_ff + 2'(req_fire) - 2'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `MFBA_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")
   `MFBA_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_data), "response not held")
   `MFBA_ASSERT(a_busy_after_accept, req_fire |=> !req_ready, "request taken while busy")
   `MFBA_ASSERT(a_rsp_has_request, rsp_fire |-> inflight_ff != 2'd0, "response without request")
   `MFBA_ASSERT(a_inflight_bound, inflight_ff != 2'd3, "more than two transactions in flight")

endmodule

bind msb_first_bitstream_access_core mfba_checker u_mfba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_read_value   (rsp_chan.read_value),
   .rsp_fetched_byte (rsp_chan.fetched_byte),
   .rsp_overrun      (rsp_chan.overrun)
);
